>>> src/pnq_pkg.sv
// Package for the palette nearest color quantizer.
// Holds the state and command encodings, widths, the search control struct and the RGB565 key.
// No dependencies.
package pnq_pkg;

  localparam int COLOR_W       = 24;
  localparam int IDX_W         = 8;
  localparam int MEMO_KEY_BITS = 16;
  localparam int EPOCH_W       = 8;
  localparam int MEMO_W        = EPOCH_W + IDX_W;
  localparam int DIST_W        = 18;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
  localparam logic               REG_FIRST_SEARCHED = 1'b0;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_PIXEL = 2'd2
  } pnq_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } pnq_state_t;

  typedef struct packed {
    logic             init;
    logic             issue;
    logic [IDX_W-1:0] idx;
  } pnq_scan_t;

  function automatic logic [MEMO_KEY_BITS-1:0] key565(input logic [COLOR_W-1:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

>>> src/pnq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pnq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/pnq_search.sv
// Distance pipeline and running minimum for the palette scan.
// Depends on pnq_pkg; fed by the palette RAM read port.
module pnq_search
  import pnq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  pnq_scan_t          scan,
  input  logic [COLOR_W-1:0] pal_rdata,
  input  logic [COLOR_W-1:0] pixel,
  output logic [IDX_W-1:0]   best_idx,
  output logic               busy
);

  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              dist_vld_r;
  logic [IDX_W-1:0]  dist_idx_r;
  logic [DIST_W-1:0] dist_r;
  logic [DIST_W-1:0] best_d_r;
  logic [IDX_W-1:0]  best_idx_r;

  logic [7:0]        dr, dg, db;
  logic [15:0]       sr, sg, sb;
  logic [DIST_W-1:0] dist_nxt;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  always_comb begin
    dr = absdiff(pal_rdata[23:16], pixel[23:16]);
    dg = absdiff(pal_rdata[15:8], pixel[15:8]);
    db = absdiff(pal_rdata[7:0], pixel[7:0]);
    sr = 16'(dr) * 16'(dr);
    sg = 16'(dg) * 16'(dg);
    sb = 16'(db) * 16'(db);
    dist_nxt = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      dist_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= scan.issue;
      dist_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= scan.idx;
    dist_idx_r <= rd_idx_r;
    dist_r     <= dist_nxt;
    if (scan.init) begin
      best_d_r   <= '1;
      best_idx_r <= '0;
    end else if (dist_vld_r && (dist_r < best_d_r)) begin
      best_d_r   <= dist_r;
      best_idx_r <= dist_idx_r;
    end
  end

  assign best_idx = best_idx_r;
  assign busy     = rd_vld_r | dist_vld_r;

endmodule

>>> src/palette_nearest_color_quantizer.sv
// Palette nearest color quantizer: top level with command sequencer, memo and palette RAMs.
// Memo hit: the result is taken from the memo entry. Miss: the palette is scanned from the first searched entry
// to the last, one palette RAM read per cycle. One item at a time.
// Load and start items are handled in the idle state. Reset runs a memo clearing pass over all 65536 entries with
// in_tready low; the same pass runs on every 255th start item when the 8-bit epoch wraps.
module palette_nearest_color_quantizer
  import pnq_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // entry_index[7:0], rgb_color[31:8]
  input  logic [1:0]        in_tuser,   // cmd[1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [IDX_W-1:0]  out_tdata,  // palette_index[7:0]
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int PAW = $clog2(PALETTE_ENTRIES);
  localparam logic [PAW-1:0] PAL_LAST = PAW'(PALETTE_ENTRIES - 1);

  pnq_state_t              state_r, state_nxt;
  logic [EPOCH_W-1:0]      epoch_r, epoch_nxt;
  logic [MEMO_KEY_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]        out_data_r, out_data_nxt;
  logic [IDX_W-1:0]        first_r;
  logic [PAW-1:0]          scan_addr_r, scan_addr_nxt;
  logic [COLOR_W-1:0]      color_r, color_nxt;
  logic [MEMO_KEY_BITS-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]        memo_idx_r, memo_idx_nxt;
  logic                    hit_r, hit_nxt;

  logic                    in_xfer;
  logic                    out_free;
  logic                    first_in_range;
  logic                    load_in_range;
  logic [IDX_W-1:0]        in_idx;
  logic [COLOR_W-1:0]      in_color;
  logic [IDX_W-1:0]        result;

  logic                    memo_we;
  logic [MEMO_KEY_BITS-1:0] memo_waddr;
  logic [MEMO_W-1:0]       memo_wdata;
  logic [MEMO_KEY_BITS-1:0] memo_raddr;
  logic [MEMO_W-1:0]       memo_rdata;

  logic                    pal_we;
  logic [COLOR_W-1:0]      pal_rdata;

  pnq_scan_t               scan;
  logic [IDX_W-1:0]        best_idx;
  logic                    srch_busy;

  assign in_idx         = in_tdata[7:0];
  assign in_color       = in_tdata[31:8];
  assign in_xfer        = in_tvalid && in_tready;
  assign out_free       = !out_valid_r || out_tready;
  assign first_in_range = {1'b0, first_r} < 9'(PALETTE_ENTRIES);
  assign load_in_range  = {1'b0, in_idx} < 9'(PALETTE_ENTRIES);
  assign result         = hit_r ? memo_idx_r : best_idx;
  assign memo_raddr     = key565(in_color);

  pnq_ram #(
    .WIDTH (MEMO_W),
    .DEPTH (1 << MEMO_KEY_BITS)
  ) u_memo (
    .clk   (clk),
    .we    (memo_we),
    .waddr (memo_waddr),
    .wdata (memo_wdata),
    .raddr (memo_raddr),
    .rdata (memo_rdata)
  );

  pnq_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_idx[PAW-1:0]),
    .wdata (in_color),
    .raddr (scan_addr_r),
    .rdata (pal_rdata)
  );

  pnq_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .scan      (scan),
    .pal_rdata (pal_rdata),
    .pixel     (color_r),
    .best_idx  (best_idx),
    .busy      (srch_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      epoch_r     <= EPOCH_FIRST;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      epoch_r     <= epoch_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    scan_addr_r <= scan_addr_nxt;
    color_r     <= color_nxt;
    key_r       <= key_nxt;
    memo_idx_r  <= memo_idx_nxt;
    hit_r       <= hit_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    epoch_nxt     = epoch_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    scan_addr_nxt = scan_addr_r;
    color_nxt     = color_r;
    key_nxt       = key_r;
    memo_idx_nxt  = memo_idx_r;
    hit_nxt       = hit_r;
    in_tready     = 1'b0;
    memo_we       = 1'b0;
    memo_waddr    = key_r;
    memo_wdata    = {epoch_r, result};
    pal_we        = 1'b0;
    scan          = '0;
    scan.idx      = IDX_W'(scan_addr_r);

    unique case (state_r)
      ST_CLEAR: begin
        memo_we     = 1'b1;
        memo_waddr  = clr_cnt_r;
        memo_wdata  = {EPOCH_NONE, {IDX_W{1'b0}}};
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_xfer) begin
          case (in_tuser)
            CMD_LOAD: begin
              pal_we = load_in_range;
            end
            CMD_START: begin
              if (epoch_r == '1) begin
                epoch_nxt   = EPOCH_FIRST;
                clr_cnt_nxt = '0;
                state_nxt   = ST_CLEAR;
              end else begin
                epoch_nxt = epoch_r + 1'b1;
              end
            end
            CMD_PIXEL: begin
              color_nxt = in_color;
              key_nxt   = memo_raddr;
              state_nxt = ST_LOOKUP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        memo_idx_nxt = memo_rdata[IDX_W-1:0];
        if (memo_rdata[MEMO_W-1:IDX_W] == epoch_r) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          hit_nxt       = 1'b0;
          scan.init     = 1'b1;
          scan_addr_nxt = first_r[PAW-1:0];
          state_nxt     = first_in_range ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        scan.issue = 1'b1;
        if (scan_addr_r == PAL_LAST) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_addr_nxt = scan_addr_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!srch_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          memo_we       = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = result;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_FIRST_SEARCHED)) begin
      first_r <= cfg_pwdata[IDX_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_FIRST_SEARCHED) ? CFG_DW'(first_r) : '0;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_CLEAR |-> epoch_r != EPOCH_NONE)
    else $error("live epoch equals the invalid tag");

  a_lookup_after_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOOKUP |-> $past(in_tvalid && in_tready && (in_tuser == CMD_PIXEL)))
    else $error("memo lookup without a pixel transfer");

  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> !srch_busy)
    else $error("result taken while the distance pipeline holds data");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> IDX_W'(scan_addr_r) >= first_r)
    else $error("scan below the first searched entry");

endmodule

>>> verif/tb.sv
// Testbench for palette_nearest_color_quantizer: stream stimulus, APB register writes with read-back and
// a self-checking nearest-index tracker with its own palette, RGB565 memo and search.
// Depends on pnq_pkg and the quantizer RTL only.
`timescale 1ns / 100ps

module tb;
  import pnq_pkg::*;

  localparam logic [1:0]        CMD_UNUSED     = 2'd3;
  localparam logic [CFG_AW-1:0] ADDR_FIRST     = CFG_AW'(4 * int'(REG_FIRST_SEARCHED));
  localparam int                CYCLE_LIMIT    = 3_000_000;
  localparam int                DRAIN_CYCLES   = 300;
  localparam int                PHASE_ITEMS    = 80;

  class nearest_index_tracker;
    bit [COLOR_W-1:0] palette [256];
    bit [IDX_W-1:0]   memo [bit [MEMO_KEY_BITS-1:0]];
    bit [IDX_W-1:0]   first_entry;
    bit [IDX_W-1:0]   expected_idx [$];
    int               errors;

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function int pending();
      return expected_idx.size();
    endfunction

    function void set_first(bit [IDX_W-1:0] v);
      first_entry = v;
    endfunction

    function int sq_dist(bit [COLOR_W-1:0] a, bit [COLOR_W-1:0] b);
      int dr, dg, db;
      dr = int'(a[23:16]) - int'(b[23:16]);
      dg = int'(a[15:8]) - int'(b[15:8]);
      db = int'(a[7:0]) - int'(b[7:0]);
      return dr * dr + dg * dg + db * db;
    endfunction

    function bit [IDX_W-1:0] nearest_entry(bit [COLOR_W-1:0] color);
      bit [IDX_W-1:0] best;
      longint         best_d;
      int             d;
      best   = '0;
      best_d = 64'hffff_ffff;
      for (int i = first_entry; i < 256; i++) begin
        d = sq_dist(palette[i], color);
        if (d < best_d) begin
          best_d = d;
          best   = IDX_W'(i);
        end
      end
      return best;
    endfunction

    // note an accepted input transfer
    function void note_item(logic [1:0] cmd, bit [IDX_W-1:0] idx, bit [COLOR_W-1:0] color);
      bit [MEMO_KEY_BITS-1:0] k;
      case (cmd)
        CMD_LOAD: palette[idx] = color;
        CMD_START: memo.delete();
        CMD_PIXEL: begin
          k = {color[23:19], color[15:10], color[7:3]};
          if (!memo.exists(k)) memo[k] = nearest_entry(color);
          expected_idx.push_back(memo[k]);
        end
        default: ;
      endcase
    endfunction

    // check an accepted output transfer
    function void check_index(bit [IDX_W-1:0] got);
      bit [IDX_W-1:0] want;
      if (expected_idx.size() == 0) begin
        flag($sformatf("index %0d with no pixel pending", got));
      end else begin
        want = expected_idx.pop_front();
        if (got !== want) flag($sformatf("palette_index expected %0d got %0d", want, got));
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [31:0]       in_tdata;   // entry_index[7:0], rgb_color[31:8]
  logic [1:0]        in_tuser;   // cmd[1:0]
  logic              out_tvalid;
  logic              out_tready;
  logic [IDX_W-1:0]  out_tdata;  // palette_index[7:0]
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  nearest_index_tracker tracker;
  bit [COLOR_W-1:0]     recent_colors [$];
  int                   cycles;
  int                   gap_mode, gap_mode_left;
  int                   rdy_mode, rdy_mode_left, stall_left;

  palette_nearest_color_quantizer DUT (.*);

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_index(out_tdata);
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      if (rdy_mode_left == 0) begin
        rdy_mode      = $urandom_range(0, 2);
        rdy_mode_left = $urandom_range(50, 300);
      end else begin
        rdy_mode_left--;
      end
      case (rdy_mode)
        0: stall_left = 0;
        1: stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        default: begin
          if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(10, 50);
          else stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
        end
      endcase
      out_tready <= (stall_left == 0);
    end
  end

  function int pick_gap();
    int r;
    if (gap_mode_left == 0) begin
      gap_mode      = $urandom_range(0, 2);
      gap_mode_left = $urandom_range(20, 80);
    end else begin
      gap_mode_left--;
    end
    if (gap_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called and returns at a falling edge
  task automatic send_item(logic [1:0] cmd, bit [IDX_W-1:0] idx, bit [COLOR_W-1:0] color);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {color, idx};
    do @(posedge clk); while (!in_tready);
    tracker.note_item(cmd, idx, color);
    if (cmd == CMD_PIXEL) begin
      recent_colors.push_back(color);
      if (recent_colors.size() > 16) void'(recent_colors.pop_front());
    end
    @(negedge clk);
  endtask

  task automatic pixel(bit [COLOR_W-1:0] color);
    send_item(CMD_PIXEL, '0, color);
  endtask

  task automatic load(bit [IDX_W-1:0] idx, bit [COLOR_W-1:0] color);
    send_item(CMD_LOAD, idx, color);
  endtask

  // hold until every pixel has its result and the block has gone quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    @(negedge clk);
  endtask

  // write the register, read it back; called and returns at a falling edge
  task automatic set_first_entry(bit [IDX_W-1:0] v);
    logic [CFG_DW-1:0] rd;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= ADDR_FIRST;
    cfg_pwdata  <= CFG_DW'(v);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    tracker.set_first(v);
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== CFG_DW'(v)) tracker.flag($sformatf("first_searched_entry read %0d wrote %0d", rd, v));
  endtask

  function bit [COLOR_W-1:0] pick_color();
    int r;
    bit [COLOR_W-1:0] c;
    r = $urandom_range(0, 99);
    if (r < 40 || recent_colors.size() == 0) return COLOR_W'($urandom);
    c = recent_colors[$urandom_range(0, recent_colors.size() - 1)];
    if (r < 65) return c;
    if (r < 80) return c ^ (COLOR_W'($urandom) & 24'h070307);
    return tracker.palette[$urandom_range(0, 255)] ^ (COLOR_W'($urandom) & 24'h0f0f0f);
  endfunction

  task automatic random_phase(int count);
    int sent, r;
    bit [COLOR_W-1:0] c;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        pixel(pick_color());
        sent++;
      end else if (r < 91) begin
        if ($urandom_range(0, 9) < 3) c = tracker.palette[$urandom_range(0, 255)];
        else c = COLOR_W'($urandom);
        load(IDX_W'($urandom), c);
        sent++;
      end else if (r < 94) begin
        send_item(CMD_START, IDX_W'($urandom), COLOR_W'($urandom));
        sent++;
      end else begin
        send_item(CMD_UNUSED, IDX_W'($urandom), COLOR_W'($urandom));
      end
    end
  endtask

  initial begin
    bit [IDX_W-1:0] phase_first [6];
    tracker       = new();
    cycles        = 0;
    gap_mode_left = 0;
    rdy_mode_left = 0;
    stall_left    = 0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    out_tready    = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // search only the top eight entries, all of them written first
    set_first_entry(8'd248);
    load(8'd248, 24'h000000);
    load(8'd249, 24'h000000);
    load(8'd250, 24'hffffff);
    load(8'd251, 24'hff0000);
    load(8'd252, 24'h00ff00);
    load(8'd253, 24'h0000ff);
    load(8'd254, 24'h808080);
    load(8'd255, 24'hffffff);
    pixel(24'h000000);
    pixel(24'hffffff);
    pixel(24'hff0000);
    pixel(24'h00ff00);
    pixel(24'h0000ff);
    pixel(24'h7f7f7f);
    pixel(24'h070307);
    send_item(CMD_UNUSED, 8'hff, 24'hffffff);
    load(8'd254, 24'h000001);
    pixel(24'h7f7f7f);
    send_item(CMD_START, 8'h00, 24'h000000);
    pixel(24'h7f7f7f);
    pixel(24'h010203);

    // register change leaves the memo answering until the next start
    settle();
    set_first_entry(8'd255);
    pixel(24'h000000);
    send_item(CMD_START, 8'hff, 24'hffffff);
    pixel(24'h000000);

    settle();
    set_first_entry(8'd0);
    for (int i = 0; i < 256; i++) begin
      if (i > 0 && $urandom_range(0, 9) == 0) load(IDX_W'(i), tracker.palette[$urandom_range(0, i - 1)]);
      else load(IDX_W'(i), COLOR_W'($urandom));
    end

    phase_first[0] = 8'd0;
    phase_first[1] = 8'd255;
    phase_first[2] = 8'd128;
    phase_first[3] = IDX_W'($urandom);
    phase_first[4] = 8'd1;
    phase_first[5] = IDX_W'($urandom);
    foreach (phase_first[p]) begin
      settle();
      set_first_entry(phase_first[p]);
      random_phase(PHASE_ITEMS);
    end

    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.pending() != 0) tracker.flag($sformatf("%0d results missing", tracker.pending()));
    if (tracker.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/pnq_pkg.sv
src/pnq_ram.sv
src/pnq_search.sv
src/palette_nearest_color_quantizer.sv
verif/tb.sv
